FILE: rtl/core/vector_rotation_toward_force_defines.svh
// assertion macros for the heading rotation block
`ifndef VECTOR_ROTATION_TOWARD_FORCE_DEFINES_SVH
`define VECTOR_ROTATION_TOWARD_FORCE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define VRTF_AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define VRTF_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/vrtf_pkg.sv
// shared constants, types and tables of the heading rotation pipeline
package vrtf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int ANG_IN_W  = 20;
    localparam int ANG_SHIFT = 30 - FRAC_BITS;
    localparam int ANG_W     = 40;
    localparam int CS_W      = 34;
    localparam int MG_W      = 30;
    localparam int SUM_W     = 62;
    localparam int ROOT_W    = 31;
    localparam int K_W       = 34;
    localparam int CORDIC_STEPS = 30;
    localparam int MOD_STEPS = (FRAC_BITS < 17) ? (18 - FRAC_BITS) : 1;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 40'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 40'sd1686629713;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 40'sd6746518852;
    localparam logic [ANG_W-1:0]        TWO_PI_U    = 40'd6746518852;
    localparam logic signed [CS_W-1:0]  CORDIC_GAIN = 34'sd652032874;

    // pipeline latencies and stage numbers, counted from the accepting edge
    localparam int L_CR  = 7;
    localparam int L_SQ  = ROOT_W;
    localparam int L_DV  = ROOT_W + 1;
    localparam int L_CO  = 34 + MOD_STEPS;
    localparam int S_CR  = L_CR;
    localparam int S_SQ  = S_CR + L_SQ;
    localparam int S_DV  = S_SQ + L_DV;
    localparam int S_N   = S_DV + 1;
    localparam int S_KP  = S_N + 1;
    localparam int S_K   = S_KP + 1;
    localparam int S_FP  = S_K + 1;
    localparam int S_OUT = S_FP + 1;

    typedef struct packed {
        logic [2:0][MG_W-1:0] mg;
        logic [2:0]           neg;
        logic                 degen;
    } t_norm;

    function automatic logic signed [CS_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [CS_W-1:0] v;
        case (idx)
            5'd0:  v = 34'sh03243F6A8;
            5'd1:  v = 34'sh01DAC6705;
            5'd2:  v = 34'sh00FADBAFC;
            5'd3:  v = 34'sh007F56EA6;
            5'd4:  v = 34'sh003FEAB76;
            5'd5:  v = 34'sh001FFD55B;
            5'd6:  v = 34'sh000FFFAAA;
            5'd7:  v = 34'sh0007FFF55;
            5'd8:  v = 34'sh0003FFFEA;
            5'd9:  v = 34'sh0001FFFFD;
            5'd10: v = 34'sh0000FFFFF;
            5'd11: v = 34'sh00007FFFF;
            5'd12: v = 34'sh00003FFFF;
            5'd13: v = 34'sh00001FFFF;
            5'd14: v = 34'sh00000FFFF;
            5'd15: v = 34'sh000007FFF;
            5'd16: v = 34'sh000003FFF;
            5'd17: v = 34'sh000001FFF;
            5'd18: v = 34'sh000000FFF;
            5'd19: v = 34'sh0000007FF;
            5'd20: v = 34'sh0000003FF;
            5'd21: v = 34'sh0000001FF;
            5'd22: v = 34'sh0000000FF;
            5'd23: v = 34'sh00000007F;
            5'd24: v = 34'sh00000003F;
            5'd25: v = 34'sh00000001F;
            5'd26: v = 34'sh00000000F;
            5'd27: v = 34'sh000000008;
            5'd28: v = 34'sh000000004;
            5'd29: v = 34'sh000000002;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/vrtf_cross.sv
// cross product, magnitude normalization to 30 bits and sum of squares
module vrtf_cross (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [vrtf_pkg::DW-1:0]     i_h [3],
    input  logic signed [vrtf_pkg::DW-1:0]     i_f [3],
    output vrtf_pkg::t_norm                    o_norm,
    output logic [vrtf_pkg::SUM_W-1:0]         o_sum
);
    import vrtf_pkg::*;

    logic signed [63:0] r_p [6];
    logic signed [63:0] r_c [3];
    logic [63:0]        r_mag3 [3];
    logic [2:0]         r_neg3;
    logic               r_dg3;
    logic [63:0]        r_mag4 [3];
    logic [6:0]         r_len4;
    logic [2:0]         r_neg4;
    logic               r_dg4;
    logic [MG_W-1:0]    r_mg5 [3];
    logic [2:0]         r_neg5;
    logic               r_dg5;
    logic [59:0]        r_sq6 [3];
    logic [MG_W-1:0]    r_mg6 [3];
    logic [2:0]         r_neg6;
    logic               r_dg6;
    logic [SUM_W-1:0]   r_sum7;
    t_norm              r_norm7;
    logic [63:0]        n_any;
    logic [6:0]         n_len;
    logic [63:0]        n_sh [3];

    // significant length of the largest magnitude, taken from the or of all three
    always_comb begin
        n_any = r_mag3[0] | r_mag3[1] | r_mag3[2];
        n_len = '0;
        for (int b = 0; b < 64; b++) begin
            if (n_any[b]) begin
                n_len = 7'(b + 1);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_len4 > 7'd30) begin
                n_sh[i] = r_mag4[i] >> (r_len4 - 7'd30);
            end else begin
                n_sh[i] = r_mag4[i] << (7'd30 - r_len4);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= 64'(i_h[1]) * 64'(i_f[2]);
            r_p[1] <= 64'(i_h[2]) * 64'(i_f[1]);
            r_p[2] <= 64'(i_h[2]) * 64'(i_f[0]);
            r_p[3] <= 64'(i_h[0]) * 64'(i_f[2]);
            r_p[4] <= 64'(i_h[0]) * 64'(i_f[1]);
            r_p[5] <= 64'(i_h[1]) * 64'(i_f[0]);

            for (int i = 0; i < 3; i++) begin
                r_c[i] <= r_p[2*i] - r_p[2*i+1];
            end

            for (int i = 0; i < 3; i++) begin
                r_mag3[i] <= r_c[i][63] ? (~r_c[i] + 64'd1) : r_c[i];
                r_neg3[i] <= r_c[i][63];
            end
            r_dg3 <= (r_c[0] == 64'sd0) && (r_c[1] == 64'sd0) && (r_c[2] == 64'sd0);

            r_mag4 <= r_mag3;
            r_len4 <= n_len;
            r_neg4 <= r_neg3;
            r_dg4  <= r_dg3;

            for (int i = 0; i < 3; i++) begin
                r_mg5[i] <= n_sh[i][MG_W-1:0];
            end
            r_neg5 <= r_neg4;
            r_dg5  <= r_dg4;

            for (int i = 0; i < 3; i++) begin
                r_sq6[i] <= 60'(r_mg5[i]) * 60'(r_mg5[i]);
            end
            r_mg6  <= r_mg5;
            r_neg6 <= r_neg5;
            r_dg6  <= r_dg5;

            r_sum7 <= SUM_W'(r_sq6[0]) + SUM_W'(r_sq6[1]) + SUM_W'(r_sq6[2]);
            for (int i = 0; i < 3; i++) begin
                r_norm7.mg[i] <= r_mg6[i];
            end
            r_norm7.neg   <= r_neg6;
            r_norm7.degen <= r_dg6;
        end
    end

    assign o_norm = r_norm7;
    assign o_sum  = r_sum7;

endmodule

FILE: rtl/core/vrtf_isqrt.sv
// pipelined integer square root, one result bit per stage
module vrtf_isqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [vrtf_pkg::SUM_W-1:0]    i_val,
    output logic [vrtf_pkg::ROOT_W-1:0]   o_root
);
    import vrtf_pkg::*;

    localparam int REM_W = ROOT_W + 2;

    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SUM_W-1:0]  r_val  [ROOT_W];
    logic [REM_W-1:0]  n_rem  [ROOT_W];
    logic [ROOT_W-1:0] n_root [ROOT_W];
    logic [SUM_W-1:0]  n_val  [ROOT_W];
    logic [REM_W-1:0]  s_rem  [ROOT_W];
    logic [ROOT_W-1:0] s_root [ROOT_W];
    logic [SUM_W-1:0]  s_val  [ROOT_W];
    logic [REM_W+1:0]  s_rt   [ROOT_W];
    logic [REM_W+1:0]  s_tr   [ROOT_W];

    always_comb begin
        for (int k = 0; k < ROOT_W; k++) begin
            if (k == 0) begin
                s_rem[k]  = '0;
                s_root[k] = '0;
                s_val[k]  = i_val;
            end else begin
                s_rem[k]  = r_rem[k-1];
                s_root[k] = r_root[k-1];
                s_val[k]  = r_val[k-1];
            end
            // bring down the next two bits, try root*4+1
            s_rt[k] = {s_rem[k], s_val[k][SUM_W-1 -: 2]};
            s_tr[k] = {2'b00, s_root[k], 2'b01};
            if (s_rt[k] >= s_tr[k]) begin
                n_rem[k]  = REM_W'(s_rt[k] - s_tr[k]);
                n_root[k] = {s_root[k][ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = REM_W'(s_rt[k]);
                n_root[k] = {s_root[k][ROOT_W-2:0], 1'b0};
            end
            n_val[k] = s_val[k] << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_val  <= n_val;
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

FILE: rtl/core/vrtf_div.sv
// pipelined restoring divider for one normal component, rounded to nearest
module vrtf_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [vrtf_pkg::MG_W-1:0]     i_mg,
    input  logic [vrtf_pkg::ROOT_W-1:0]   i_m,
    output logic [vrtf_pkg::ROOT_W-1:0]   o_q
);
    import vrtf_pkg::*;

    localparam int NUM_W = 2 * MG_W + 1;
    localparam int STEPS = ROOT_W;

    logic [NUM_W-1:0]  w_num;
    logic [ROOT_W-1:0] r_rem [STEPS+1];
    logic [ROOT_W-1:0] r_low [STEPS+1];
    logic [ROOT_W-1:0] r_dm  [STEPS+1];
    logic [ROOT_W-1:0] r_q   [STEPS+1];
    logic [ROOT_W:0]   s_t   [STEPS];

    // numerator mg * 2^30 + m/2; the quotient fits in ROOT_W bits
    assign w_num = NUM_W'({i_mg, {MG_W{1'b0}}}) + NUM_W'(i_m >> 1);

    always_comb begin
        for (int k = 0; k < STEPS; k++) begin
            s_t[k] = {r_rem[k], r_low[k][ROOT_W-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= ROOT_W'(w_num[NUM_W-1:ROOT_W]);
            r_low[0] <= w_num[ROOT_W-1:0];
            r_dm[0]  <= i_m;
            r_q[0]   <= '0;
            for (int k = 0; k < STEPS; k++) begin
                if (s_t[k] >= {1'b0, r_dm[k]}) begin
                    r_rem[k+1] <= ROOT_W'(s_t[k] - {1'b0, r_dm[k]});
                    r_q[k+1]   <= {r_q[k][ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= ROOT_W'(s_t[k]);
                    r_q[k+1]   <= {r_q[k][ROOT_W-2:0], 1'b0};
                end
                r_low[k+1] <= r_low[k] << 1;
                r_dm[k+1]  <= r_dm[k];
            end
        end
    end

    assign o_q = r_q[STEPS];

endmodule

FILE: rtl/core/vrtf_cordic.sv
// angle reduction and pipelined rotation-mode cordic giving cos and sin in q2.30
module vrtf_cordic (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [vrtf_pkg::ANG_IN_W-1:0] i_angle,
    output logic signed [vrtf_pkg::DW-1:0]      o_cos,
    output logic signed [vrtf_pkg::DW-1:0]      o_sin
);
    import vrtf_pkg::*;

    logic signed [ANG_W-1:0] w_ang;
    logic [ANG_W-1:0]        r_mag0;
    logic                    r_neg0;
    logic [ANG_W-1:0]        r_mm [MOD_STEPS];
    logic                    r_mn [MOD_STEPS];
    logic [ANG_W-1:0]        s_src [MOD_STEPS];
    logic [ANG_W-1:0]        s_thr [MOD_STEPS];
    logic signed [ANG_W-1:0] n_r0;
    logic signed [ANG_W-1:0] r_r1;
    logic signed [CS_W-1:0]  r_x [CORDIC_STEPS+1];
    logic signed [CS_W-1:0]  r_y [CORDIC_STEPS+1];
    logic signed [CS_W-1:0]  r_z [CORDIC_STEPS+1];
    logic                    r_fl [CORDIC_STEPS+1];
    logic signed [DW-1:0]    r_cos;
    logic signed [DW-1:0]    r_sin;

    assign w_ang = ANG_W'(i_angle) <<< ANG_SHIFT;
    assign n_r0  = r_mn[MOD_STEPS-1] ? -$signed(r_mm[MOD_STEPS-1])
                                     : $signed(r_mm[MOD_STEPS-1]);

    // remainder by 2*pi on the magnitude, largest multiple first
    always_comb begin
        for (int j = 0; j < MOD_STEPS; j++) begin
            s_src[j] = (j == 0) ? r_mag0 : r_mm[(j == 0) ? 0 : j - 1];
            s_thr[j] = TWO_PI_U << (MOD_STEPS - 1 - j);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag0 <= w_ang[ANG_W-1] ? ANG_W'(-w_ang) : ANG_W'(w_ang);
            r_neg0 <= w_ang[ANG_W-1];

            for (int j = 0; j < MOD_STEPS; j++) begin
                r_mm[j] <= (s_src[j] >= s_thr[j]) ? s_src[j] - s_thr[j] : s_src[j];
                r_mn[j] <= (j == 0) ? r_neg0 : r_mn[(j == 0) ? 0 : j - 1];
            end

            if (n_r0 > PI_Q30) begin
                r_r1 <= n_r0 - TWO_PI_Q30;
            end else if (n_r0 < -PI_Q30) begin
                r_r1 <= n_r0 + TWO_PI_Q30;
            end else begin
                r_r1 <= n_r0;
            end

            // fold into the right half plane, negate both results at the end
            r_x[0] <= CORDIC_GAIN;
            r_y[0] <= '0;
            if (r_r1 > HALF_PI_Q30) begin
                r_z[0]  <= CS_W'(r_r1 - PI_Q30);
                r_fl[0] <= 1'b1;
            end else if (r_r1 < -HALF_PI_Q30) begin
                r_z[0]  <= CS_W'(r_r1 + PI_Q30);
                r_fl[0] <= 1'b1;
            end else begin
                r_z[0]  <= CS_W'(r_r1);
                r_fl[0] <= 1'b0;
            end

            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_q30(5'(i));
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_q30(5'(i));
                end
                r_fl[i+1] <= r_fl[i];
            end

            r_cos <= r_fl[CORDIC_STEPS] ? DW'(-r_x[CORDIC_STEPS]) : DW'(r_x[CORDIC_STEPS]);
            r_sin <= r_fl[CORDIC_STEPS] ? DW'(-r_y[CORDIC_STEPS]) : DW'(r_y[CORDIC_STEPS]);
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

FILE: rtl/core/vector_rotation_toward_force.sv
// Rotates a heading vector toward a force direction by a given angle.
// Input channel: i_in_valid / o_in_ready carry one item of heading (x, y, z),
// force (x, y, z) and turn angle, all signed fixed point.
// Output channel: o_out_valid / i_out_ready carry the rotated heading, each
// component saturated to 32 bits, and a degenerate flag set when heading and
// force are parallel or either is zero (the result is then heading*cos).
// One item per cycle is taken and delivered while the receiver keeps up.
// The path from acceptance to o_out_valid is set by the cross product and normalize
// stages (7), a 31-stage square root, a 32-stage divider per component, the
// normal cross heading stages (3) and the final multiply and saturate (2);
// the cordic angle path runs in parallel and is shorter.
// Reset clears all valid bits; nothing else is held between items.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_in_ready drops; no item is lost or repeated.
`include "vector_rotation_toward_force_defines.svh"

module vector_rotation_toward_force (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [vrtf_pkg::DW-1:0]        i_head_x,
    input  logic signed [vrtf_pkg::DW-1:0]        i_head_y,
    input  logic signed [vrtf_pkg::DW-1:0]        i_head_z,
    input  logic signed [vrtf_pkg::DW-1:0]        i_force_x,
    input  logic signed [vrtf_pkg::DW-1:0]        i_force_y,
    input  logic signed [vrtf_pkg::DW-1:0]        i_force_z,
    input  logic signed [vrtf_pkg::ANG_IN_W-1:0]  i_turn_angle,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [vrtf_pkg::DW-1:0]        o_rot_x,
    output logic signed [vrtf_pkg::DW-1:0]        o_rot_y,
    output logic signed [vrtf_pkg::DW-1:0]        o_rot_z,
    output logic                                  o_degenerate
);
    import vrtf_pkg::*;

    logic                  en;
    logic [S_OUT:1]        r_vld;
    logic signed [DW-1:0]  w_h [3];
    logic signed [DW-1:0]  w_f [3];
    logic signed [DW-1:0]  r_h [1:S_K][3];
    t_norm                 w_norm;
    logic [SUM_W-1:0]      w_sum;
    logic [ROOT_W-1:0]     w_root;
    logic [2:0][MG_W-1:0]  r_mg [S_CR+1:S_SQ];
    logic [3:0]            r_sd [S_CR+1:S_OUT];
    logic [ROOT_W-1:0]     w_q [3];
    logic signed [DW-1:0]  r_n [3];
    logic signed [63:0]    r_pk [6];
    logic signed [64:0]    s_kt [3];
    logic signed [K_W-1:0] r_k [3];
    logic signed [DW-1:0]  w_cos;
    logic signed [DW-1:0]  w_sin;
    logic signed [DW-1:0]  r_co [L_CO+1:S_K];
    logic signed [DW-1:0]  r_si [L_CO+1:S_K];
    logic signed [63:0]    r_pa [3];
    logic signed [65:0]    r_pb [3];
    logic signed [66:0]    s_acc [3];
    logic signed [66:0]    s_sh [3];
    logic signed [DW-1:0]  r_rot [3];

    // the pipeline moves as one; it holds only while a result waits
    assign en         = ~r_vld[S_OUT] | i_out_ready;
    assign o_in_ready = en;

    assign w_h[0] = i_head_x;
    assign w_h[1] = i_head_y;
    assign w_h[2] = i_head_z;
    assign w_f[0] = i_force_x;
    assign w_f[1] = i_force_y;
    assign w_f[2] = i_force_z;

    vrtf_cross u_cross (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_h    (w_h),
        .i_f    (w_f),
        .o_norm (w_norm),
        .o_sum  (w_sum)
    );

    vrtf_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (w_sum),
        .o_root (w_root)
    );

    for (genvar g = 0; g < 3; g++) begin : g_div
        vrtf_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_mg  (r_mg[S_SQ][g]),
            .i_m   (w_root),
            .o_q   (w_q[g])
        );
    end

    vrtf_cordic u_cordic (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_turn_angle),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[S_OUT-1:1], i_in_valid};
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s_kt[i]  = 65'(r_pk[2*i]) - 65'(r_pk[2*i+1]) + 65'sd536870912;
            s_acc[i] = 67'(r_pa[i]) + 67'(r_pb[i]) + 67'sd536870912;
            s_sh[i]  = s_acc[i] >>> 30;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h[1] <= w_h;
            for (int j = 2; j <= S_K; j++) begin
                r_h[j] <= r_h[j-1];
            end

            r_mg[S_CR+1] <= w_norm.mg;
            for (int j = S_CR + 2; j <= S_SQ; j++) begin
                r_mg[j] <= r_mg[j-1];
            end

            r_sd[S_CR+1] <= {w_norm.degen, w_norm.neg};
            for (int j = S_CR + 2; j <= S_OUT; j++) begin
                r_sd[j] <= r_sd[j-1];
            end

            r_co[L_CO+1] <= w_cos;
            r_si[L_CO+1] <= w_sin;
            for (int j = L_CO + 2; j <= S_K; j++) begin
                r_co[j] <= r_co[j-1];
                r_si[j] <= r_si[j-1];
            end

            // signed unit normal in q2.30, zero when degenerate
            for (int i = 0; i < 3; i++) begin
                if (r_sd[S_DV][3]) begin
                    r_n[i] <= '0;
                end else if (r_sd[S_DV][i]) begin
                    r_n[i] <= -$signed({1'b0, w_q[i]});
                end else begin
                    r_n[i] <= $signed({1'b0, w_q[i]});
                end
            end

            r_pk[0] <= 64'(r_n[1]) * 64'(r_h[S_N][2]);
            r_pk[1] <= 64'(r_n[2]) * 64'(r_h[S_N][1]);
            r_pk[2] <= 64'(r_n[2]) * 64'(r_h[S_N][0]);
            r_pk[3] <= 64'(r_n[0]) * 64'(r_h[S_N][2]);
            r_pk[4] <= 64'(r_n[0]) * 64'(r_h[S_N][1]);
            r_pk[5] <= 64'(r_n[1]) * 64'(r_h[S_N][0]);

            for (int i = 0; i < 3; i++) begin
                r_k[i]  <= K_W'(s_kt[i] >>> 30);
                r_pa[i] <= 64'(r_h[S_K][i]) * 64'(r_co[S_K]);
                r_pb[i] <= 66'(r_k[i]) * 66'(r_si[S_K]);
                if (s_sh[i] > 67'sd2147483647) begin
                    r_rot[i] <= 32'sh7FFFFFFF;
                end else if (s_sh[i] < -67'sd2147483648) begin
                    r_rot[i] <= 32'sh80000000;
                end else begin
                    r_rot[i] <= DW'(s_sh[i]);
                end
            end
        end
    end

    assign o_out_valid  = r_vld[S_OUT];
    assign o_rot_x      = r_rot[0];
    assign o_rot_y      = r_rot[1];
    assign o_rot_z      = r_rot[2];
    assign o_degenerate = r_sd[S_OUT][3];

    `VRTF_AST_IMP(a_normal_nonzero, r_vld[S_N] && !r_sd[S_N][3],
        r_n[0] != 0 || r_n[1] != 0 || r_n[2] != 0, "normal is zero for a non-degenerate item")
    `VRTF_AST_NXT(a_degen_no_turn, en && r_vld[S_N] && r_sd[S_N][3],
        r_pk[0] == 0 && r_pk[1] == 0 && r_pk[2] == 0 && r_pk[3] == 0 && r_pk[4] == 0 && r_pk[5] == 0,
        "degenerate item has a nonzero turn term")
    `VRTF_AST_IMP(a_cos_bound, r_vld[S_K],
        r_co[S_K] <= 32'sd1073807360 && r_co[S_K] >= -32'sd1073807360, "cosine out of range")

endmodule
